>>> rtl/core/mv1rx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mv1rx_pkg
// Shared constants and helpers for the MAVLink v1 frame receiver.
// ----------------------------------------------------------------------------
package mv1rx_pkg;

	// Default geometry of the slot memory and the slot ring
	localparam int SLOT_BYTES_DEF  = 64;
	localparam int QUEUE_SLOTS_DEF = 4;

	// Frame layout: sync, length, sequence, system id, component id, message id
	localparam int HEADER_BYTES = 6;

	localparam logic [7:0]  SYNC_BYTE = 8'hFE;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'h8408;

	// Messages that close the CRC with a nonzero extra byte
	localparam logic [7:0] MSG_ID_HEARTBEAT        = 8'd0;
	localparam logic [7:0] MSG_ID_OPTICAL_FLOW     = 8'd100;
	localparam logic [7:0] MSG_ID_HIL_OPTICAL_FLOW = 8'd106;

	localparam logic [7:0] EXTRA_HEARTBEAT        = 8'd50;
	localparam logic [7:0] EXTRA_OPTICAL_FLOW     = 8'd175;
	localparam logic [7:0] EXTRA_HIL_OPTICAL_FLOW = 8'd138;
	localparam logic [7:0] EXTRA_NONE             = 8'd0;

	function automatic logic [7:0] msg_extra_byte(input logic [7:0] msg_id);
		logic [7:0] extra;
		unique case (msg_id)
			MSG_ID_HEARTBEAT:        extra = EXTRA_HEARTBEAT;
			MSG_ID_OPTICAL_FLOW:     extra = EXTRA_OPTICAL_FLOW;
			MSG_ID_HIL_OPTICAL_FLOW: extra = EXTRA_HIL_OPTICAL_FLOW;
			default:                 extra = EXTRA_NONE;
		endcase
		return extra;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/mv1rx_crc_byte.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mv1rx_crc_byte
// One byte of CRC-16/MCRF4XX: reflected, LSB first, eight shift steps.
// ----------------------------------------------------------------------------
module mv1rx_crc_byte
	import mv1rx_pkg::*;
(
	input  wire logic [15:0] crc_in,
	input  wire logic [7:0]  data,
	output logic      [15:0] crc_out
);

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule
`default_nettype wire

>>> rtl/core/mavlink_v1_frame_receiver_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mavlink_v1_frame_receiver_unit
// Frames MAVLink v1 packets from a byte stream, checks the CRC and emits
// slot memory writes plus a completion report for each good frame.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                      Content
// s_axis    in   s_axis_tvalid / s_axis_tready  one received byte + consumer head
// m_axis    out  m_axis_tvalid / m_axis_tready  store write + frame report
//
// Every item passes through the input register and then the result register;
// a new item is taken every cycle while m_axis does not stall.
// The frame state (CRC byte step, position, ring pointers) updates in the
// cycle that an item leaves the input register. A stall on m_axis holds
// both registers; s_axis_tready drops only while the input register is full.
// Reset clears handshake flags, position, fill slot and overrun and sets the tail slot to the last slot; nothing else.
//
module mavlink_v1_frame_receiver_unit
	import mv1rx_pkg::*;
#(
	parameter int SLOT_BYTES  = SLOT_BYTES_DEF,
	parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
	localparam int SLOT_W  = $clog2(QUEUE_SLOTS),
	localparam int POS_W   = $clog2(SLOT_BYTES),
	localparam int IN_RAW  = 8 + SLOT_W,
	localparam int IN_W    = ((IN_RAW + 7) / 8) * 8,
	localparam int OUT_RAW = 1 + SLOT_W + POS_W + 8 + 1 + SLOT_W + 8 + 16 + 1,
	localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,

	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// rx_byte, consumer_head
	input  wire logic [IN_W-1:0]  s_axis_tdata,

	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// store_valid, store_slot, store_offset, store_byte, frame_done,
	// frame_slot, frame_msg_id, frame_crc, overrun
	output logic [OUT_W-1:0]      m_axis_tdata
);

	localparam int LEN_W = $clog2(SLOT_BYTES - 7);
	localparam int CMP_W = POS_W + 1;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_SLOTS - 1);
	localparam logic [8:0]        LEN_LIMIT = 9'(SLOT_BYTES - 8);
	localparam logic [CMP_W-1:0]  HDR_LEN   = CMP_W'(HEADER_BYTES);
	localparam logic [POS_W-1:0]  POS_SYNC  = POS_W'(0);
	localparam logic [POS_W-1:0]  POS_LEN   = POS_W'(1);
	localparam logic [POS_W-1:0]  POS_MSGID = POS_W'(5);

	// Input register
	logic              valid_s1;
	logic [7:0]        rx_byte_s1;
	logic [SLOT_W-1:0] head_s1;
	logic              advance;

	// Frame state
	logic [POS_W-1:0]  pos_q;
	logic [LEN_W-1:0]  len_q;
	logic [15:0]       crc_q;
	logic [7:0]        msg_id_q;
	logic [SLOT_W-1:0] rslot_q;
	logic [SLOT_W-1:0] tail_q;
	logic              ovr_q;

	// Next state and result
	logic [POS_W-1:0]  pos_d;
	logic [LEN_W-1:0]  len_d;
	logic [15:0]       crc_d;
	logic [7:0]        msg_id_d;
	logic [SLOT_W-1:0] rslot_d;
	logic [SLOT_W-1:0] tail_d;
	logic              ovr_d;
	logic              store;
	logic              done;
	logic [SLOT_W-1:0] rslot_next;

	logic [15:0]       crc_start;
	logic [7:0]        crc_data;
	logic [15:0]       crc_new;
	logic [CMP_W-1:0]  hdr_total;
	logic [CMP_W-1:0]  pos_ext;
	logic              in_body;
	logic              too_long;

	// Result register
	logic               out_valid_q;
	logic [OUT_RAW-1:0] result_q;
	logic [OUT_RAW-1:0] result_d;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Hold the byte until the result register has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			rx_byte_s1 <= s_axis_tdata[7:0];
			head_s1    <= s_axis_tdata[8 +: SLOT_W];
		end
	end

	// Header bytes after the sync byte and payload bytes go through the CRC; at the CRC low byte the
	// per-message extra byte closes it instead.
	assign pos_ext   = {1'b0, pos_q};
	assign hdr_total = HDR_LEN + CMP_W'(len_q);
	assign in_body   = (pos_q == POS_LEN) || (pos_ext < hdr_total);
	assign too_long  = {1'b0, rx_byte_s1} > LEN_LIMIT;
	assign crc_start = (pos_q == POS_LEN) ? CRC_INIT : crc_q;
	assign crc_data  = in_body ? rx_byte_s1 : msg_extra_byte(msg_id_q);
	assign rslot_next = (rslot_q == LAST_SLOT) ? '0 : rslot_q + 1'b1;

	mv1rx_crc_byte u_crc (
		.crc_in  (crc_start),
		.data    (crc_data),
		.crc_out (crc_new)
	);

	always_comb begin
		pos_d    = pos_q;
		len_d    = len_q;
		crc_d    = crc_q;
		msg_id_d = msg_id_q;
		rslot_d  = rslot_q;
		tail_d   = tail_q;
		ovr_d    = ovr_q;
		store    = 1'b0;
		done     = 1'b0;

		if (pos_q == POS_SYNC) begin
			// Hunt: drop anything but the sync byte
			store = (rx_byte_s1 == SYNC_BYTE);
		end else if (pos_q == POS_LEN && too_long) begin
			pos_d = POS_SYNC;
		end else if (in_body) begin
			if (pos_q == POS_LEN) begin
				len_d = LEN_W'(rx_byte_s1);
			end
			if (pos_q == POS_MSGID) begin
				msg_id_d = rx_byte_s1;
			end
			crc_d = crc_new;
			store = 1'b1;
		end else if (pos_ext == hdr_total) begin
			crc_d = crc_new;
			if (rx_byte_s1 == crc_new[7:0]) begin
				store = 1'b1;
			end else begin
				pos_d = POS_SYNC;
			end
		end else begin
			// CRC high byte: never stored, always back to hunting
			if (rx_byte_s1 == crc_q[15:8]) begin
				done    = 1'b1;
				tail_d  = rslot_q;
				rslot_d = rslot_next;
				if (rslot_next == head_s1) begin
					ovr_d = 1'b1;
				end
			end
			pos_d = POS_SYNC;
		end

		if (store) begin
			pos_d = pos_q + 1'b1;
		end

		result_d = {ovr_d,
			done ? crc_q : 16'h0000,
			done ? msg_id_q : 8'h00,
			tail_d,
			done,
			rx_byte_s1,
			pos_q,
			rslot_q,
			store};
	end

	// Advance the frame state once per item leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_SYNC;
			rslot_q <= '0;
			tail_q  <= LAST_SLOT;
			ovr_q   <= 1'b0;
		end else if (advance) begin
			pos_q   <= pos_d;
			rslot_q <= rslot_d;
			tail_q  <= tail_d;
			ovr_q   <= ovr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			len_q    <= len_d;
			crc_q    <= crc_d;
			msg_id_q <= msg_id_d;
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(result_q);

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MAVLink v1 frame receiver. Drives byte
// streams (noise, good frames, bad CRCs, oversize lengths) into s_axis,
// predicts every m_axis item with a cycle-free parser model and compares
// the two field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import mv1rx_pkg::*;

	// Port widths for the default geometry: 4 slots of 64 bytes
	localparam int IN_W  = 16;
	localparam int OUT_W = 48;
	localparam int RPT_W = 45;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum {FAULT_NONE, FAULT_CRC_LOW, FAULT_CRC_HIGH} frame_fault_t;

	// One m_axis item, lowest field last so that store_valid lands on bit 0
	typedef struct packed {
		logic        ovr;
		logic [15:0] crc;
		logic [7:0]  msg_id;
		logic [1:0]  fslot;
		logic        done;
		logic [7:0]  sbyte;
		logic [5:0]  offset;
		logic [1:0]  sslot;
		logic        wr;
	} rx_report_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	mavlink_v1_frame_receiver_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		// rx_byte, consumer_head
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		// store_valid, store_slot, store_offset, store_byte, frame_done,
		// frame_slot, frame_msg_id, frame_crc, overrun
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	// Parser state as the bench sees it
	int          frame_pos = 0;
	int          pay_len = 0;
	logic [15:0] crc_acc = '0;
	logic [7:0]  cur_msg_id = '0;
	int          fill_slot = 0;
	int          tail_slot = QUEUE_SLOTS_DEF - 1;
	logic        overrun_seen = 1'b0;

	rx_report_t  due_reports [$];

	// Run bookkeeping
	int   error_count = 0;
	int   items_accepted = 0;
	int   results_checked = 0;
	int   frames_committed = 0;
	int   crc_rejects = 0;
	int   length_rejects = 0;
	int   bytes_stored = 0;
	int   cycle_count = 0;

	// Stimulus knobs
	bit   quiet = 1'b0;          // no idling on either side
	bit   overrun_allowed = 1'b0;
	bit   aim_overrun = 1'b0;
	logic holding = 1'b0;        // long receiver hold-off
	int   stall_left = 0;

	// ------------------------------------------------------------------
	// CRC-16/MCRF4XX, one byte, reflected polynomial
	// ------------------------------------------------------------------
	function automatic logic [15:0] crc_mcrf_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// Per-message byte that closes the CRC
	function automatic logic [7:0] extra_byte_of(input logic [7:0] id);
		case (id)
			MSG_ID_HEARTBEAT:        return EXTRA_HEARTBEAT;
			MSG_ID_OPTICAL_FLOW:     return EXTRA_OPTICAL_FLOW;
			MSG_ID_HIL_OPTICAL_FLOW: return EXTRA_HIL_OPTICAL_FLOW;
			default:                 return EXTRA_NONE;
		endcase
	endfunction

	// Consumer head for the next byte: keep it off the slot that a commit
	// would move to unless overrun is wanted
	function automatic logic [1:0] pick_head();
		logic [1:0] next_slot;
		next_slot = 2'((fill_slot + 1) % QUEUE_SLOTS_DEF);
		if (aim_overrun)
			return next_slot;
		if (overrun_allowed)
			return 2'($urandom_range(0, 3));
		return next_slot + 2'($urandom_range(1, 3));
	endfunction

	// ------------------------------------------------------------------
	// Parse one accepted byte and queue the m_axis item it must produce
	// ------------------------------------------------------------------
	task automatic parse_byte(input logic [7:0] b, input logic [1:0] head);
		rx_report_t r;
		int         pos;
		bit         store;
		r = '0;
		pos = frame_pos;
		store = 1'b0;
		r.sslot = 2'(fill_slot);
		r.offset = 6'(pos);
		r.sbyte = b;
		if (pos == 0) begin
			// hunting: only the sync byte opens a frame
			store = (b == SYNC_BYTE);
		end else if (pos == 1 && int'(b) > SLOT_BYTES_DEF - 8) begin
			// oversize length: drop it and hunt again
			frame_pos = 0;
			length_rejects++;
		end else begin
			if (pos == 1) begin
				pay_len = int'(b);
				crc_acc = CRC_INIT;
			end
			if (pos < HEADER_BYTES + pay_len) begin
				if (pos == 5)
					cur_msg_id = b;
				crc_acc = crc_mcrf_byte(crc_acc, b);
				store = 1'b1;
			end else if (pos == HEADER_BYTES + pay_len) begin
				crc_acc = crc_mcrf_byte(crc_acc, extra_byte_of(cur_msg_id));
				if (b == crc_acc[7:0]) begin
					store = 1'b1;
				end else begin
					frame_pos = 0;
					crc_rejects++;
				end
			end else begin
				// CRC high byte: never stored, always ends the frame
				if (b == crc_acc[15:8]) begin
					r.done = 1'b1;
					r.crc = crc_acc;
					r.msg_id = cur_msg_id;
					tail_slot = fill_slot;
					fill_slot = (fill_slot + 1 >= QUEUE_SLOTS_DEF) ? 0 : fill_slot + 1;
					if (fill_slot == int'(head))
						overrun_seen = 1'b1;
					frames_committed++;
				end else begin
					crc_rejects++;
				end
				frame_pos = 0;
			end
		end
		if (store) begin
			frame_pos = pos + 1;
			bytes_stored++;
		end
		r.wr = store;
		r.fslot = 2'(tail_slot);
		r.ovr = overrun_seen;
		due_reports.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Offer one item on s_axis, hold it until taken, then predict
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic [1:0] head);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_W - 10){1'b0}}, head, b};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_accepted++;
		parse_byte(b, head);
	endtask

	// Build and send one frame with random sequence, system and component ids and random payload
	task automatic send_frame(input int len, input logic [7:0] msg_id,
			input frame_fault_t fault);
		logic [15:0] crc;
		logic [7:0]  b;
		crc = CRC_INIT;
		send_byte(SYNC_BYTE, pick_head());
		b = 8'(len);
		crc = crc_mcrf_byte(crc, b);
		send_byte(b, pick_head());
		// sequence, system id, component id
		for (int i = 0; i < 3; i++) begin
			b = 8'($urandom);
			crc = crc_mcrf_byte(crc, b);
			send_byte(b, pick_head());
		end
		crc = crc_mcrf_byte(crc, msg_id);
		send_byte(msg_id, pick_head());
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			crc = crc_mcrf_byte(crc, b);
			send_byte(b, pick_head());
		end
		crc = crc_mcrf_byte(crc, extra_byte_of(msg_id));
		b = crc[7:0];
		if (fault == FAULT_CRC_LOW)
			b ^= 8'($urandom_range(1, 255));
		send_byte(b, pick_head());
		if (fault != FAULT_CRC_LOW) begin
			b = crc[15:8];
			if (fault == FAULT_CRC_HIGH)
				b ^= 8'($urandom_range(1, 255));
			send_byte(b, pick_head());
		end
	endtask

	// Drop valid once the stream is done
	task automatic stop_sending();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hunt state drops anything but sync, including both byte extremes
	task automatic test_hunt_noise();
		send_byte(8'h00, 2'd2);
		send_byte(8'hFF, 2'd3);
		send_byte(8'h55, 2'd0);
	endtask

	// Shortest good frame with the heartbeat extra byte
	task automatic test_heartbeat();
		send_frame(0, MSG_ID_HEARTBEAT, FAULT_NONE);
	endtask

	// Lengths above the slot limit end the frame; the failing byte, even a
	// sync value, is not taken as a new sync
	task automatic test_length_limit();
		send_byte(SYNC_BYTE, pick_head());
		send_byte(8'(SLOT_BYTES_DEF - 7), pick_head());
		send_byte(SYNC_BYTE, pick_head());
		send_byte(SYNC_BYTE, pick_head());
		send_byte(8'hFF, pick_head());
	endtask

	// Wrong CRC low byte on an optical flow frame
	task automatic test_crc_low_bad();
		send_frame(0, MSG_ID_OPTICAL_FLOW, FAULT_CRC_LOW);
	endtask

	// Wrong CRC high byte on a hil optical flow frame, then a good one
	task automatic test_crc_high_bad();
		send_frame(0, MSG_ID_HIL_OPTICAL_FLOW, FAULT_CRC_HIGH);
		send_frame(1, MSG_ID_HIL_OPTICAL_FLOW, FAULT_NONE);
	endtask

	// Mostly well-formed frames with random content, plus broken ones and
	// noise; stop once enough items have gone in
	task automatic test_random_traffic(input int n_items);
		int          stop_at;
		int          pick;
		int          len;
		logic [7:0]  id;
		stop_at = items_accepted + n_items;
		while (items_accepted < stop_at) begin
			pick = $urandom_range(0, 99);
			len = $urandom_range(0, 12);
			if ($urandom_range(0, 19) == 0)
				len = SLOT_BYTES_DEF - 8;
			else if ($urandom_range(0, 19) == 0)
				len = $urandom_range(13, SLOT_BYTES_DEF - 8);
			case ($urandom_range(0, 3))
				0:       id = MSG_ID_HEARTBEAT;
				1:       id = MSG_ID_OPTICAL_FLOW;
				2:       id = MSG_ID_HIL_OPTICAL_FLOW;
				default: id = 8'($urandom);
			endcase
			if (pick < 78) begin
				send_frame(len, id, FAULT_NONE);
			end else if (pick < 85) begin
				send_frame(len, id, FAULT_CRC_LOW);
			end else if (pick < 92) begin
				send_frame(len, id, FAULT_CRC_HIGH);
			end else if (pick < 96) begin
				send_byte(SYNC_BYTE, pick_head());
				send_byte(8'($urandom_range(SLOT_BYTES_DEF - 7, 255)), pick_head());
			end else begin
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom), pick_head());
			end
		end
	endtask

	// Hold the receiver off for a long stretch while frames keep coming,
	// so both pipeline registers fill and s_axis_tready drops
	task automatic test_backpressure();
		fork
			begin
				@(negedge clk);
				holding <= 1'b1;
				repeat (200) @(negedge clk);
				holding <= 1'b0;
			end
		join_none
		repeat (6)
			send_frame($urandom_range(4, 12), 8'($urandom), FAULT_NONE);
	endtask

	// Commit a frame onto the consumer head, then check the flag sticks
	task automatic test_overrun();
		overrun_allowed = 1'b1;
		aim_overrun = 1'b1;
		send_frame(2, MSG_ID_HEARTBEAT, FAULT_NONE);
		aim_overrun = 1'b0;
		send_frame(3, 8'($urandom), FAULT_NONE);
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stall bursts, or the long hold
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (holding) begin
			m_axis_tready <= 1'b0;
		end else if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		error_count++;
		if (error_count <= 40)
			$display("tb_top: mismatch on %s at result %0d: got 0x%0h, want 0x%0h",
				what, results_checked, got, want);
	endtask

	task automatic check_field(input string what, input longint unsigned got,
			input longint unsigned want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin
		rx_report_t got;
		rx_report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = rx_report_t'(m_axis_tdata[RPT_W-1:0]);
			if (due_reports.size() == 0) begin
				report_mismatch("result with nothing expected", m_axis_tdata, 0);
			end else begin
				want = due_reports.pop_front();
				check_field("store_valid", got.wr, want.wr);
				check_field("store_slot", got.sslot, want.sslot);
				check_field("store_offset", got.offset, want.offset);
				check_field("store_byte", got.sbyte, want.sbyte);
				check_field("frame_done", got.done, want.done);
				check_field("frame_slot", got.fslot, want.fslot);
				check_field("frame_msg_id", got.msg_id, want.msg_id);
				check_field("frame_crc", got.crc, want.crc);
				check_field("overrun", got.ovr, want.ovr);
				check_field("tdata padding", m_axis_tdata[OUT_W-1:RPT_W], 0);
			end
			results_checked++;
		end
	end

	// ------------------------------------------------------------------
	// Cycle budget
	// ------------------------------------------------------------------
	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_top: cycle limit hit with %0d results outstanding", due_reports.size());
		$display("tb_top: done, errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_hunt_noise();
		test_heartbeat();
		test_length_limit();
		test_crc_low_bad();
		test_crc_high_bad();
		test_random_traffic(1000);
		test_backpressure();
		test_overrun();
		// last stretch: no idling on either side
		quiet = 1'b1;
		test_random_traffic(300);
		stop_sending();

		// drain, then give the pipeline time to show any stray item
		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (due_reports.size() != 0)
			report_mismatch("results never delivered", due_reports.size(), 0);

		$display("tb_top: %0d bytes in, %0d results checked, %0d slot writes",
			items_accepted, results_checked, bytes_stored);
		$display("tb_top: %0d frames committed, %0d CRC rejects, %0d length rejects, overrun %0d",
			frames_committed, crc_rejects, length_rejects, overrun_seen);
		if (error_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/mv1rx_pkg.sv
rtl/core/mv1rx_crc_byte.sv
rtl/core/mavlink_v1_frame_receiver_unit.sv
test/tb_top.sv
